FILE: sv/vpzc_pkg.sv
// Package with request codes, lane control types and shared constants.
`default_nettype none
package vpzc_pkg;
	typedef enum logic [2:0] {
		REQ_SET_BOUNDS  = 3'd0,
		REQ_SET_EXTENTS = 3'd1,
		REQ_LIVE_EDGE   = 3'd2,
		REQ_PAN         = 3'd3,
		REQ_ZOOM        = 3'd4,
		REQ_RESET       = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOVE,
		ST_DIV,
		ST_ZOOMFIX,
		ST_CLAMP,
		ST_DONE
	} state_t;

	localparam int NDC_FRAC   = 14;
	localparam int SCALE_FRAC = 16;
	localparam int NDC_W      = 16;
	localparam int SCALE_W    = 24;
	localparam logic [15:0] MIN_Y_SPAN_RST = 16'd328;

	// Per-lane command from the sequencer.
	typedef struct packed {
		logic load_move;
		logic is_pan;
		logic div_start;
		logic load_zoom;
	} lane_ctl_t;
endpackage
`default_nettype wire

FILE: sv/vpzc_div.sv
// Serial restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module vpzc_div import vpzc_pkg::*; #(
	parameter int NW = 56,
	parameter int DW = 24
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [NW-1:0] num,
	input  wire logic        [DW-1:0] den,
	output logic signed [NW-1:0]      quo,
	output logic                      busy
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] mag_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;
	logic [DW:0]   shifted;

	assign shifted = {rem_q[DW-1:0], mag_q[NW-1]};
	assign trial   = shifted - {1'b0, den_q};

	// Each cycle moves one dividend bit into the partial remainder.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			busy  <= 1'b0;
		end else if (start) begin
			cnt_q <= CW'(NW);
			busy  <= 1'b1;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= num[NW-1] ? NW'(-num) : num;
			neg_q <= num[NW-1];
			den_q <= den;
			rem_q <= '0;
		end else if (busy) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				mag_q <= {mag_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				mag_q <= {mag_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? NW'(-mag_q) : mag_q;
endmodule
`default_nettype wire

FILE: sv/vpzc_lane.sv
// One axis lane: pan or zoom move of a window, with two serial dividers.
`default_nettype none
module vpzc_lane import vpzc_pkg::*; #(
	parameter int CW = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lane_ctl_t            ctl,
	input  wire logic signed [CW-1:0] lo,
	input  wire logic signed [CW-1:0] hi,
	input  wire logic signed [NDC_W-1:0] ndc,
	input  wire logic [SCALE_W-1:0]   scale,
	output logic signed [CW-1:0]      new_lo,
	output logic signed [CW-1:0]      new_hi,
	output logic                      busy
);
	localparam int SW  = CW + 1;
	localparam int PW  = SW + NDC_W + 1;
	localparam int NW  = SW + 1 + SCALE_FRAC + 1;
	localparam logic signed [NW:0] CMAX = (NW+1)'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [NW:0] CMIN = -CMAX - 1;

	logic signed [SW-1:0]  span;
	logic signed [PW-1:0]  prod;
	logic signed [PW-1:0]  focus_sum;
	logic signed [CW+1:0]  focus_s1;
	logic signed [CW+1:0]  delta_s1;
	logic signed [CW-1:0]  lo_s1, hi_s1;
	logic signed [NW-1:0]  nlo, nhi, qlo, qhi;
	logic                  blo, bhi;
	logic signed [NW:0]    sum_lo, sum_hi;

	assign span = SW'(hi) - SW'(lo);
	assign prod = PW'(ndc) * PW'(span);
	assign focus_sum = ((PW'(lo) + PW'(hi)) <<< NDC_FRAC) + prod;

	function automatic logic signed [CW-1:0] sat(input logic signed [NW:0] v);
		if (v > CMAX) return CMAX[CW-1:0];
		if (v < CMIN) return CMIN[CW-1:0];
		return v[CW-1:0];
	endfunction

	// Pan delta or zoom focus, registered after the multiply.
	always_ff @(posedge clk) begin
		if (ctl.load_move) begin
			lo_s1    <= lo;
			hi_s1    <= hi;
			delta_s1 <= (CW+2)'((-prod) >>> (NDC_FRAC + 1));
			focus_s1 <= (CW+2)'(focus_sum >>> (NDC_FRAC + 1));
		end
	end

	assign nlo = NW'(focus_s1 - (CW+2)'(lo_s1)) <<< SCALE_FRAC;
	assign nhi = NW'((CW+2)'(hi_s1) - focus_s1) <<< SCALE_FRAC;

	vpzc_div #(.NW(NW), .DW(SCALE_W)) u_div_lo (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.num(nlo), .den(scale), .quo(qlo), .busy(blo));
	vpzc_div #(.NW(NW), .DW(SCALE_W)) u_div_hi (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.num(nhi), .den(scale), .quo(qhi), .busy(bhi));

	assign busy = blo | bhi;

	// Pan adds the delta; zoom steps out from the focus by the quotients.
	always_comb begin
		if (ctl.is_pan) begin
			sum_lo = (NW+1)'(lo_s1) + (NW+1)'(delta_s1);
			sum_hi = (NW+1)'(hi_s1) + (NW+1)'(delta_s1);
		end else begin
			sum_lo = (NW+1)'(focus_s1) - (NW+1)'(qlo);
			sum_hi = (NW+1)'(focus_s1) + (NW+1)'(qhi);
		end
	end

	// The saturated edges are ready once the dividers are idle.
	assign new_lo = sat(sum_lo);
	assign new_hi = sat(sum_hi);
endmodule
`default_nettype wire

FILE: sv/vpzc_clamp.sv
// Clamps one axis of the window into the data bounds.
`default_nettype none
module vpzc_clamp #(
	parameter int CW = 32
) (
	input  wire logic signed [CW-1:0] dlo,
	input  wire logic signed [CW-1:0] dhi,
	input  wire logic signed [CW-1:0] vlo,
	input  wire logic signed [CW-1:0] vhi,
	output logic signed [CW-1:0]      olo,
	output logic signed [CW-1:0]      ohi
);
	logic signed [CW:0] dlen, span, a, b;

	always_comb begin
		dlen = (CW+1)'(dhi) - (CW+1)'(dlo);
		span = (CW+1)'(vhi) - (CW+1)'(vlo);
		if (dlen < 1) dlen = 1;
		if (span < 1) span = 1;
		a = (CW+1)'(vlo);
		b = (CW+1)'(vhi);
		if (span >= dlen) begin
			a = (CW+1)'(dlo);
			b = (CW+1)'(dhi);
		end else begin
			if (a < (CW+1)'(dlo)) begin
				a = (CW+1)'(dlo);
				b = (CW+1)'(dlo) + span;
			end
			if (b > (CW+1)'(dhi)) begin
				b = (CW+1)'(dhi);
				a = (CW+1)'(dhi) - span;
			end
			if (a < (CW+1)'(dlo)) a = (CW+1)'(dlo);
		end
		olo = a[CW-1:0];
		ohi = b[CW-1:0];
	end
endmodule
`default_nettype wire

FILE: sv/viewport_pan_zoom_clamp.sv
// Top level: request sequencer, x and y lanes, merge and clamp of the window.
// Pan and valid zooms go through the move state; zoom then starts the lane dividers
// in divide, and both wait in zoom-fix until the dividers are idle; other requests go
// straight to clamp. All end in clamp and done. One request is in flight at a time,
// so no new one is taken until the result is accepted. Reset gives a -1..1 window
// on both axes, revision 0, tracking on, last edge 1.0 and min_y_span 328.
`default_nettype none
module viewport_pan_zoom_clamp import vpzc_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic [2:0] req_type,
	input  wire logic signed [COORD_WIDTH-1:0] x_lo,
	input  wire logic signed [COORD_WIDTH-1:0] x_hi,
	input  wire logic signed [COORD_WIDTH-1:0] y_lo,
	input  wire logic signed [COORD_WIDTH-1:0] y_hi,
	input  wire logic signed [COORD_WIDTH-1:0] edge_x,
	input  wire logic signed [NDC_W-1:0] ndc_x,
	input  wire logic signed [NDC_W-1:0] ndc_y,
	input  wire logic [SCALE_W-1:0] scale_x,
	input  wire logic [SCALE_W-1:0] scale_y,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic signed [COORD_WIDTH-1:0] vis_x_lo,
	output logic signed [COORD_WIDTH-1:0] vis_x_hi,
	output logic signed [COORD_WIDTH-1:0] vis_y_lo,
	output logic signed [COORD_WIDTH-1:0] vis_y_hi,
	output logic [31:0] change_count,
	output logic        following_edge,
	output logic        accepted
);
	localparam int CW = COORD_WIDTH;
	localparam logic signed [CW-1:0] ONE = CW'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [CW+1:0] CMAX = (CW+2)'({1'b0, {(CW-1){1'b1}}});
	localparam logic signed [CW+1:0] CMIN = -CMAX - 1;

	state_t state_q, state_d;
	logic [15:0] min_span_q;
	logic signed [CW-1:0] db_q [4];
	logic signed [CW-1:0] vw_q [4];
	logic signed [CW-1:0] last_edge_q;
	logic [31:0] rev_q;
	logic track_q, ok_q, bump_q, pan_q;
	logic [2:0] type_q;
	logic signed [NDC_W-1:0] nx_q, ny_q;
	logic [SCALE_W-1:0] sx_q, sy_q;
	lane_ctl_t ctl;
	logic bx, by;
	logic signed [CW-1:0] zx_lo, zx_hi, zy_lo, zy_hi;
	logic signed [CW-1:0] cx_lo, cx_hi, cy_lo, cy_hi;
	logic signed [CW+1:0] ex0, ex1, dedge;
	logic signed [CW:0] yspan_new, yspan_old;
	logic in_acc;

	function automatic logic signed [CW-1:0] sat1(input logic signed [CW+1:0] v);
		if (v > CMAX) return CMAX[CW-1:0];
		if (v < CMIN) return CMIN[CW-1:0];
		return v[CW-1:0];
	endfunction

	function automatic logic type_t_is(input logic [2:0] t, input req_t r);
		return t == r;
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	// Lanes, one per axis.
	vpzc_lane #(.CW(CW)) u_lane_x (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .lo(vw_q[0]), .hi(vw_q[1]),
		.ndc(nx_q), .scale(sx_q), .new_lo(zx_lo), .new_hi(zx_hi), .busy(bx));
	vpzc_lane #(.CW(CW)) u_lane_y (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .lo(vw_q[2]), .hi(vw_q[3]),
		.ndc(ny_q), .scale(sy_q), .new_lo(zy_lo), .new_hi(zy_hi), .busy(by));

	vpzc_clamp #(.CW(CW)) u_clamp_x (
		.dlo(db_q[0]), .dhi(db_q[1]), .vlo(vw_q[0]), .vhi(vw_q[1]),
		.olo(cx_lo), .ohi(cx_hi));
	vpzc_clamp #(.CW(CW)) u_clamp_y (
		.dlo(db_q[2]), .dhi(db_q[3]), .vlo(vw_q[2]), .vhi(vw_q[3]),
		.olo(cy_lo), .ohi(cy_hi));

	assign dedge = (CW+2)'(edge_x) - (CW+2)'(last_edge_q);
	assign ex0 = (CW+2)'(vw_q[0]) + dedge;
	assign ex1 = (CW+2)'(vw_q[1]) + dedge;
	assign yspan_new = (CW+1)'(zy_hi) - (CW+1)'(zy_lo);
	assign yspan_old = (CW+1)'(vw_q[3]) - (CW+1)'(vw_q[2]);

	// Sequencer next state and lane commands.
	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.is_pan = pan_q;
		unique case (state_q)
			ST_IDLE: ;
			ST_MOVE: begin
				ctl.load_move = 1'b1;
				state_d = pan_q ? ST_ZOOMFIX : ST_DIV;
			end
			ST_DIV: begin
				ctl.div_start = 1'b1;
				state_d = ST_ZOOMFIX;
			end
			ST_ZOOMFIX: begin
				if (!(bx || by)) begin
					ctl.load_zoom = 1'b1;
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: state_d = ST_DONE;
			ST_DONE: if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_IDLE && in_valid) begin
			if ((type_t_is(req_type, REQ_PAN)) ||
			    (type_t_is(req_type, REQ_ZOOM) && scale_x != '0 && scale_y != '0))
				state_d = ST_MOVE;
			else state_d = ST_CLAMP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_span_q <= MIN_Y_SPAN_RST;
		else if (cfg_we) min_span_q <= cfg_wdata;
	end

	// Architectural state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_q[0] <= -ONE; db_q[1] <= ONE; db_q[2] <= -ONE; db_q[3] <= ONE;
			vw_q[0] <= -ONE; vw_q[1] <= ONE; vw_q[2] <= -ONE; vw_q[3] <= ONE;
			last_edge_q <= ONE;
			rev_q <= '0;
			track_q <= 1'b1;
			ok_q <= 1'b0;
			bump_q <= 1'b0;
			pan_q <= 1'b0;
			type_q <= '0;
			nx_q <= '0; ny_q <= '0; sx_q <= '0; sy_q <= '0;
		end else if (in_acc) begin
			type_q <= req_type;
			pan_q <= (req_type == REQ_PAN);
			nx_q <= ndc_x; ny_q <= ndc_y; sx_q <= scale_x; sy_q <= scale_y;
			ok_q <= 1'b0;
			bump_q <= 1'b0;
			unique case (req_type)
				REQ_SET_BOUNDS, REQ_SET_EXTENTS: begin
					if (x_lo < x_hi && y_lo < y_hi) begin
						ok_q <= 1'b1; bump_q <= 1'b1;
						db_q[0] <= x_lo; db_q[1] <= x_hi; db_q[2] <= y_lo; db_q[3] <= y_hi;
						if (req_type == REQ_SET_BOUNDS) begin
							vw_q[0] <= x_lo; vw_q[1] <= x_hi;
							vw_q[2] <= y_lo; vw_q[3] <= y_hi;
							track_q <= 1'b1;
							last_edge_q <= x_hi;
						end
					end
				end
				REQ_LIVE_EDGE: begin
					ok_q <= 1'b1;
					if (track_q && edge_x != last_edge_q) begin
						bump_q <= 1'b1;
						vw_q[0] <= sat1(ex0);
						vw_q[1] <= sat1(ex1);
					end
					last_edge_q <= edge_x;
				end
				REQ_PAN: begin
					ok_q <= 1'b1; bump_q <= 1'b1; track_q <= 1'b0;
				end
				REQ_ZOOM: begin
					if (scale_x != '0 && scale_y != '0) begin
						ok_q <= 1'b1; bump_q <= 1'b1; track_q <= 1'b0;
					end
				end
				REQ_RESET: begin
					ok_q <= 1'b1; bump_q <= 1'b1;
					vw_q <= db_q;
					track_q <= 1'b1;
					last_edge_q <= db_q[1];
				end
				default: ;
			endcase
		end else if (ctl.load_zoom) begin
			// Merge the lanes' results into the window.
			vw_q[0] <= zx_lo; vw_q[1] <= zx_hi;
			if (!pan_q && yspan_new < (CW+1)'($signed({1'b0, min_span_q})) &&
			    yspan_new < yspan_old) begin
				vw_q[2] <= vw_q[2]; vw_q[3] <= vw_q[3];
			end else begin
				vw_q[2] <= zy_lo; vw_q[3] <= zy_hi;
			end
		end else if (state_q == ST_CLAMP) begin
			if (bump_q && type_q != REQ_SET_BOUNDS && type_q != REQ_RESET) begin
				vw_q[0] <= cx_lo; vw_q[1] <= cx_hi; vw_q[2] <= cy_lo; vw_q[3] <= cy_hi;
			end
			if (bump_q) rev_q <= rev_q + 1'b1;
		end
	end

	assign out_valid      = (state_q == ST_DONE);
	assign vis_x_lo       = vw_q[0];
	assign vis_x_hi       = vw_q[1];
	assign vis_y_lo       = vw_q[2];
	assign vis_y_hi       = vw_q[3];
	assign change_count   = rev_q;
	assign following_edge = track_q;
	assign accepted       = ok_q;

	// A transaction is never taken while a result is pending.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	// The revision moves only in the clamp step.
	a_rev_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLAMP) |=> $stable(rev_q)) else $error("revision moved early");
	// A rejected request never bumps the revision.
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !accepted) |-> !bump_q) else $error("rejected but bumped");
endmodule
`default_nettype wire

FILE: tb/tb_viewport_pan_zoom_clamp.sv
// Self-checking testbench for the viewport pan, zoom and clamp block.
`default_nettype none
module tb_viewport_pan_zoom_clamp;
	import vpzc_pkg::*;

	typedef struct {
		logic [2:0] kind;
		logic signed [31:0] xl, xh, yl, yh, edg;
		logic signed [15:0] nx, ny;
		logic [23:0] sx, sy;
	} view_req_t;

	typedef struct {
		logic signed [31:0] wxl, wxh, wyl, wyh;
		logic [31:0] rev;
		logic trk, ok;
	} view_res_t;

	localparam longint CMAX = 64'sd2147483647;
	localparam longint CMIN = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] req_type = '0;
	logic signed [31:0] x_lo = '0, x_hi = '0, y_lo = '0, y_hi = '0, edge_x = '0;
	logic signed [15:0] ndc_x = '0, ndc_y = '0;
	logic [23:0] scale_x = '0, scale_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] vis_x_lo, vis_x_hi, vis_y_lo, vis_y_hi;
	logic [31:0] change_count;
	logic following_edge, accepted;

	viewport_pan_zoom_clamp i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type),
		.x_lo(x_lo), .x_hi(x_hi), .y_lo(y_lo), .y_hi(y_hi), .edge_x(edge_x),
		.ndc_x(ndc_x), .ndc_y(ndc_y), .scale_x(scale_x), .scale_y(scale_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.vis_x_lo(vis_x_lo), .vis_x_hi(vis_x_hi), .vis_y_lo(vis_y_lo),
		.vis_y_hi(vis_y_hi), .change_count(change_count),
		.following_edge(following_edge), .accepted(accepted)
	);

	// Shadow of the block state used to predict each window.
	longint bnd[4];
	longint win[4];
	logic [31:0] rev_cnt;
	logic trk_on;
	longint prev_edge;
	logic [15:0] span_floor;

	view_req_t pending_reqs[$];
	view_res_t expected_windows[$];
	int err_cnt = 0;
	int gap_left = 0;
	int burst_left = 0;
	bit hold_sender = 1'b0;
	bit long_stall = 1'b0;
	bit offer_taken = 1'b0;
	int stall_cnt = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint sat_coord(longint v);
		if (v > CMAX) return CMAX;
		if (v < CMIN) return CMIN;
		return v;
	endfunction

	function automatic longint floor_div2(longint v, int s);
		if (v >= 0) return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	task automatic clamp_one(input longint dlo, input longint dhi, inout longint lo,
			inout longint hi);
		longint dlen, span;
		dlen = dhi - dlo;
		span = hi - lo;
		if (dlen < 1) dlen = 1;
		if (span < 1) span = 1;
		if (span >= dlen) begin
			lo = dlo;
			hi = dhi;
		end else begin
			if (lo < dlo) begin
				lo = dlo;
				hi = dlo + span;
			end
			if (hi > dhi) begin
				hi = dhi;
				lo = dhi - span;
			end
			if (lo < dlo) lo = dlo;
		end
	endtask

	task automatic clamp_both();
		clamp_one(bnd[0], bnd[1], win[0], win[1]);
		clamp_one(bnd[2], bnd[3], win[2], win[3]);
	endtask

	task automatic zoom_one(input longint lo, input longint hi, input longint f,
			input longint sc, output longint nlo, output longint nhi);
		longint focus, dl, dh;
		focus = floor_div2((lo + hi) * (64'sd1 <<< NDC_FRAC) + f * (hi - lo), NDC_FRAC + 1);
		dl = ((focus - lo) * (64'sd1 <<< SCALE_FRAC)) / sc;
		dh = ((hi - focus) * (64'sd1 <<< SCALE_FRAC)) / sc;
		nlo = sat_coord(focus - dl);
		nhi = sat_coord(focus + dh);
	endtask

	task automatic reset_view_state();
		bnd[0] = -65536; bnd[1] = 65536; bnd[2] = -65536; bnd[3] = 65536;
		win = bnd;
		rev_cnt = '0;
		trk_on = 1'b1;
		prev_edge = 65536;
		span_floor = MIN_Y_SPAN_RST;
	endtask

	// Advance the shadow state by one request and queue the resulting window.
	task automatic predict_window(input view_req_t r);
		view_res_t e;
		longint xl, xh, yl, yh, ed, nx, ny, dx, dy, a, b, c, d;
		bit ok;
		xl = r.xl; xh = r.xh; yl = r.yl; yh = r.yh; ed = r.edg;
		nx = r.nx; ny = r.ny;
		ok = 1'b0;
		case (r.kind)
			REQ_SET_BOUNDS, REQ_SET_EXTENTS: begin
				if (xl < xh && yl < yh) begin
					ok = 1'b1;
					bnd[0] = xl; bnd[1] = xh; bnd[2] = yl; bnd[3] = yh;
					if (r.kind == REQ_SET_BOUNDS) begin
						win = bnd;
						trk_on = 1'b1;
						prev_edge = xh;
					end else begin
						clamp_both();
					end
					rev_cnt++;
				end
			end
			REQ_LIVE_EDGE: begin
				ok = 1'b1;
				if (trk_on && ed != prev_edge) begin
					dx = ed - prev_edge;
					win[0] = sat_coord(win[0] + dx);
					win[1] = sat_coord(win[1] + dx);
					clamp_both();
					rev_cnt++;
				end
				prev_edge = ed;
			end
			REQ_PAN: begin
				dx = floor_div2(-nx * (win[1] - win[0]), NDC_FRAC + 1);
				dy = floor_div2(-ny * (win[3] - win[2]), NDC_FRAC + 1);
				ok = 1'b1;
				trk_on = 1'b0;
				win[0] = sat_coord(win[0] + dx);
				win[1] = sat_coord(win[1] + dx);
				win[2] = sat_coord(win[2] + dy);
				win[3] = sat_coord(win[3] + dy);
				clamp_both();
				rev_cnt++;
			end
			REQ_ZOOM: begin
				if (r.sx != 0 && r.sy != 0) begin
					ok = 1'b1;
					trk_on = 1'b0;
					zoom_one(win[0], win[1], nx, longint'(r.sx), a, b);
					zoom_one(win[2], win[3], ny, longint'(r.sy), c, d);
					if (d - c < longint'(span_floor) && d - c < win[3] - win[2]) begin
						c = win[2];
						d = win[3];
					end
					win[0] = a; win[1] = b; win[2] = c; win[3] = d;
					clamp_both();
					rev_cnt++;
				end
			end
			REQ_RESET: begin
				ok = 1'b1;
				win = bnd;
				trk_on = 1'b1;
				prev_edge = bnd[1];
				rev_cnt++;
			end
			default: ok = 1'b0;
		endcase
		e.wxl = win[0][31:0]; e.wxh = win[1][31:0];
		e.wyl = win[2][31:0]; e.wyh = win[3][31:0];
		e.rev = rev_cnt; e.trk = trk_on; e.ok = ok;
		expected_windows.push_back(e);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on %s: got %h, expected %h", what, got, want);
		err_cnt++;
	endtask

	function automatic view_req_t make_req(input logic [2:0] k);
		view_req_t r;
		r.kind = k;
		r.xl = $urandom; r.xh = $urandom; r.yl = $urandom; r.yh = $urandom;
		r.edg = $urandom;
		r.nx = 16'($urandom); r.ny = 16'($urandom);
		r.sx = 24'($urandom); r.sy = 24'($urandom);
		return r;
	endfunction

	// Mostly well-formed requests with moderate magnitudes, plus raw noise.
	function automatic view_req_t rand_req();
		view_req_t r;
		int pick;
		longint lo, w;
		pick = $urandom_range(0, 99);
		r = make_req(3'($urandom_range(0, 5)));
		if (pick < 8) begin
			r.kind = 3'($urandom_range(0, 7));
			return r;
		end
		if (pick < 75) begin
			lo = $signed($urandom_range(0, 32'h00FF_FFFF)) - 64'sd8388608;
			w = $urandom_range(1, 32'h00FF_FFFF);
			if ($urandom_range(0, 3) == 0) w = $urandom_range(1, 8);
			r.xl = 32'(lo); r.xh = 32'(lo + w);
			lo = $signed($urandom_range(0, 32'h00FF_FFFF)) - 64'sd8388608;
			w = $urandom_range(1, 32'h00FF_FFFF);
			if ($urandom_range(0, 3) == 0) w = $urandom_range(1, 2000);
			r.yl = 32'(lo); r.yh = 32'(lo + w);
			r.edg = 32'(prev_edge + $signed($urandom_range(0, 200000)) - 100000);
			r.sx = 24'($urandom_range(16384, 262144));
			r.sy = 24'($urandom_range(16384, 262144));
			if ($urandom_range(0, 15) == 0) r.sx = 0;
			if ($urandom_range(0, 15) == 0) r.sy = 0;
		end
		return r;
	endfunction

	// Driver: bursts of offers with random gaps between them.
	always @(negedge clk) begin
		view_req_t r;
		if (arst_n) begin
			if (in_valid && !offer_taken) begin
				// hold the offer until it is taken
			end else if (pending_reqs.size() != 0 && !hold_sender && gap_left == 0) begin
				r = pending_reqs.pop_front();
				offer_taken = 1'b0;
				in_valid <= 1'b1;
				req_type <= r.kind;
				x_lo <= r.xl; x_hi <= r.xh; y_lo <= r.yl; y_hi <= r.yh;
				edge_x <= r.edg; ndc_x <= r.nx; ndc_y <= r.ny;
				scale_x <= r.sx; scale_y <= r.sy;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
				end else begin
					burst_left--;
					if (burst_left == 0) gap_left = $urandom_range(0, 20);
				end
			end else begin
				offer_taken = 1'b0;
				in_valid <= 1'b0;
				if (gap_left != 0) gap_left--;
			end
			if (long_stall) begin
				out_ready <= 1'b0;
				stall_cnt++;
			end else begin
				out_ready <= ($urandom_range(0, 99) < 70) || (stall_cnt[6:5] == 2'b11);
				stall_cnt++;
			end
		end
	end

	// Monitor: predict at input acceptance, check at output acceptance.
	always @(posedge clk) begin
		view_req_t r;
		view_res_t e;
		if (arst_n && in_valid && in_ready) begin
			offer_taken = 1'b1;
			r.kind = req_type; r.xl = x_lo; r.xh = x_hi; r.yl = y_lo; r.yh = y_hi;
			r.edg = edge_x; r.nx = ndc_x; r.ny = ndc_y; r.sx = scale_x; r.sy = scale_y;
			predict_window(r);
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_windows.size() == 0) begin
				report_mismatch("unexpected transaction", change_count, '0);
			end else begin
				e = expected_windows.pop_front();
				if (vis_x_lo !== e.wxl) report_mismatch("vis_x_lo", vis_x_lo, e.wxl);
				if (vis_x_hi !== e.wxh) report_mismatch("vis_x_hi", vis_x_hi, e.wxh);
				if (vis_y_lo !== e.wyl) report_mismatch("vis_y_lo", vis_y_lo, e.wyl);
				if (vis_y_hi !== e.wyh) report_mismatch("vis_y_hi", vis_y_hi, e.wyh);
				if (change_count !== e.rev) report_mismatch("change_count", change_count, e.rev);
				if (following_edge !== e.trk)
					report_mismatch("following_edge", 32'(following_edge), 32'(e.trk));
				if (accepted !== e.ok) report_mismatch("accepted", 32'(accepted), 32'(e.ok));
			end
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_windows.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_span_floor(input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		span_floor = v;
	endtask

	task automatic add_req(input logic [2:0] k, input longint xl, input longint xh,
			input longint yl, input longint yh, input longint ed, input int nx,
			input int ny, input int sx, input int sy);
		view_req_t r;
		r.kind = k; r.xl = 32'(xl); r.xh = 32'(xh); r.yl = 32'(yl); r.yh = 32'(yh);
		r.edg = 32'(ed);
		r.nx = 16'(nx); r.ny = 16'(ny); r.sx = 24'(sx); r.sy = 24'(sy);
		pending_reqs.push_back(r);
	endtask

	initial begin
		int phase;
		reset_view_state();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed requests: extremes, each type and each rejection case.
		add_req(REQ_LIVE_EDGE, 0, 0, 0, 0, 65536, 0, 0, 0, 0);
		add_req(REQ_LIVE_EDGE, 0, 0, 0, 0, 100000, 0, 0, 0, 0);
		add_req(REQ_SET_BOUNDS, 5, 5, -10, 10, 0, 0, 0, 0, 0);
		add_req(REQ_SET_EXTENTS, -10, 10, 7, 3, 0, 0, 0, 0, 0);
		add_req(REQ_SET_BOUNDS, CMIN, CMAX, CMIN, CMAX, 0, 0, 0, 0, 0);
		add_req(REQ_PAN, 0, 0, 0, 0, 0, -32768, 32767, 0, 0);
		add_req(REQ_PAN, 0, 0, 0, 0, 0, 32767, -32768, 0, 0);
		add_req(REQ_ZOOM, 0, 0, 0, 0, 0, 32767, -32768, 24'hFFFFFF, 1);
		add_req(REQ_ZOOM, 0, 0, 0, 0, 0, -32768, 32767, 1, 24'hFFFFFF);
		add_req(REQ_ZOOM, 0, 0, 0, 0, 0, 0, 0, 0, 65536);
		add_req(REQ_ZOOM, 0, 0, 0, 0, 0, 0, 0, 65536, 0);
		add_req(REQ_LIVE_EDGE, 0, 0, 0, 0, CMAX, 0, 0, 0, 0);
		add_req(REQ_RESET, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_req(REQ_LIVE_EDGE, 0, 0, 0, 0, CMIN, 0, 0, 0, 0);
		add_req(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_req(3'd7, -1, -1, -1, -1, -1, -1, -1, 24'hFFFFFF, 24'hFFFFFF);
		add_req(REQ_SET_BOUNDS, -65536, 65536, -65536, 65536, 0, 0, 0, 0, 0);
		add_req(REQ_ZOOM, 0, 0, 0, 0, 0, 0, 0, 65536, 24'hFFFFFF);
		add_req(REQ_ZOOM, 0, 0, 0, 0, 0, 0, 0, 65536, 1 << 22);
		add_req(REQ_SET_EXTENTS, -1000, 1000, -30, 30, 0, 0, 0, 0, 0);
		add_req(REQ_PAN, 0, 0, 0, 0, 0, 100, -100, 0, 0);
		wait_drained();

		// Random phases under several span floor settings.
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_span_floor(16'd0);
				1: write_span_floor(16'hFFFF);
				2: write_span_floor(16'd1);
				3: write_span_floor(16'($urandom));
				default: write_span_floor(MIN_Y_SPAN_RST);
			endcase
			repeat (180) pending_reqs.push_back(rand_req());
			if (phase == 1) begin
				// Hold the receiver off long enough for the input to back up.
				long_stall = 1'b1;
				repeat (600) @(posedge clk);
				long_stall = 1'b0;
			end
			if (phase == 2) begin
				// Pause the sender until all outstanding results are back.
				while (pending_reqs.size() > 90) @(posedge clk);
				hold_sender = 1'b1;
				while (in_valid || expected_windows.size() != 0) @(posedge clk);
				hold_sender = 1'b0;
			end
			wait_drained();
		end

		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire
